>>> src/assert_macros.svh
// Assertion macros used by the hash table probe engine datapath.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("%m: implication check failed");

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("%m: next-cycle check failed");

`endif

>>> src/htpe_pkg.sv
// Shared types and constants of the hash table probe engine.
package htpe_pkg;

  // Default table geometry
  localparam int unsigned CAPACITY_DEF   = 1024;
  localparam int unsigned DATA_WIDTH_DEF = 64;

  // Fixed port widths
  localparam int unsigned KEY_W      = 64;
  localparam int unsigned DATA_OUT_W = 64;
  localparam int unsigned CNT_OUT_W  = 11;

  // Command codes
  localparam logic CMD_INSERT = 1'b0;
  localparam logic CMD_LOOKUP = 1'b1;

  // Controller states
  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_PROBE
  } htpe_state_t;

  // Controller to datapath commands
  typedef struct packed {
    logic load;    // capture a new operation, read its home slot
    logic step;    // advance the probe sequence, read the next slot
    logic finish;  // commit the operation and present its result
    logic clear;   // clear one slot of the table
  } htpe_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic cont;      // probe sequence must go on
    logic clr_last;  // clearing pass is at the final slot
  } htpe_sts_t;

endpackage

>>> src/htpe_ctrl.sv
// Controller state machine of the hash table probe engine.
module htpe_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  output htpe_pkg::htpe_cmd_t cmd,
  input  htpe_pkg::htpe_sts_t sts
);
  import htpe_pkg::*;

  htpe_state_t state_r;
  htpe_state_t state_nxt;

  // State register; reset starts the clearing pass
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    busy      = 1'b1;
    unique case (state_r)
      ST_CLEAR: begin
        cmd.clear = 1'b1;
        if (sts.clr_last) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        busy = 1'b0;
        if (start) begin
          cmd.load  = 1'b1;
          state_nxt = ST_PROBE;
        end
      end
      ST_PROBE: begin
        if (sts.cont) begin
          cmd.step = 1'b1;
        end else begin
          cmd.finish = 1'b1;
          state_nxt  = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

>>> src/htpe_datapath.sv
// Datapath of the hash table probe engine: slot memory, probe registers, count, result.
`include "assert_macros.svh"

module htpe_datapath #(
  parameter int unsigned CAPACITY   = htpe_pkg::CAPACITY_DEF,
  parameter int unsigned DATA_WIDTH = htpe_pkg::DATA_WIDTH_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  htpe_pkg::htpe_cmd_t                 cmd,
  output htpe_pkg::htpe_sts_t                 sts,
  input  logic                                in_command,
  input  logic [htpe_pkg::KEY_W-1:0]          in_key,
  input  logic [htpe_pkg::DATA_OUT_W-1:0]     in_entry_data,
  output logic                                out_valid,
  output logic                                out_hit,
  output logic [htpe_pkg::DATA_OUT_W-1:0]     out_data_out,
  output logic [htpe_pkg::CNT_OUT_W-1:0]      out_probes_taken,
  output logic                                out_overwrote,
  output logic [htpe_pkg::CNT_OUT_W-1:0]      out_entry_count
);
  import htpe_pkg::*;

  localparam int unsigned IDXW = $clog2(CAPACITY);
  localparam int unsigned SW   = IDXW + 1;
  localparam int unsigned MW   = 1 + KEY_W + DATA_WIDTH;

  // Slot memory word: {valid, key, data}
  logic [MW-1:0]         mem [CAPACITY];
  logic [MW-1:0]         rd_word_r;
  logic [IDXW-1:0]       rd_addr;
  logic                  we;
  logic [IDXW-1:0]       wa;
  logic [MW-1:0]         wd;

  // Operation and probe registers
  logic                  op_cmd_r;
  logic [KEY_W-1:0]      op_key_r;
  logic [DATA_WIDTH-1:0] op_data_r;
  logic [IDXW-1:0]       slot_r;
  logic [SW-1:0]         steps_r;
  logic [SW-1:0]         count_r;
  logic [SW-1:0]         count_nxt;
  logic [IDXW-1:0]       clr_idx_r;

  // Result registers
  logic                  out_valid_r;
  logic                  out_hit_r;
  logic [DATA_OUT_W-1:0] out_data_r;
  logic [CNT_OUT_W-1:0]  out_probes_r;
  logic                  out_over_r;
  logic [CNT_OUT_W-1:0]  out_count_r;

  logic                  rd_valid;
  logic [KEY_W-1:0]      rd_key;
  logic [DATA_WIDTH-1:0] rd_data;
  logic [IDXW-1:0]       slot_step;
  logic                  full;
  logic                  below_cap;
  logic                  key_eq;
  logic                  is_insert;
  logic                  res_hit;
  logic [DATA_OUT_W-1:0] res_data;
  logic                  res_over;
  logic                  probe_cont;
  logic                  clr_last;

  // Fields of the slot just read
  assign rd_valid = rd_word_r[MW-1];
  assign rd_key   = rd_word_r[MW-2 -: KEY_W];
  assign rd_data  = rd_word_r[DATA_WIDTH-1:0];

  // Triangular step: add the step count to the current slot
  assign slot_step = IDXW'(slot_r + IDXW'(steps_r));
  assign rd_addr   = cmd.load ? in_key[IDXW-1:0] : slot_step;

  // Probe decision
  assign is_insert = (op_cmd_r == CMD_INSERT);
  assign full      = (count_r == SW'(CAPACITY));
  assign below_cap = (steps_r < SW'(CAPACITY));
  assign key_eq    = (rd_key == op_key_r);

  assign probe_cont = is_insert ? (rd_valid && !full && below_cap)
                                : (rd_valid && !key_eq && below_cap);
  assign clr_last   = (clr_idx_r == IDXW'(CAPACITY - 1));
  assign sts        = '{cont: probe_cont, clr_last: clr_last};

  // Memory write: insert commit or clearing pass
  assign we = cmd.clear || (cmd.finish && is_insert);
  assign wa = cmd.clear ? clr_idx_r : slot_r;
  assign wd = cmd.clear ? '0 : {1'b1, op_key_r, op_data_r};

  // Slot memory, one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    rd_word_r <= mem[rd_addr];
  end

  // Operation capture and probe advance
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_cmd_r  <= in_command;
      op_key_r  <= in_key;
      op_data_r <= in_entry_data[DATA_WIDTH-1:0];
      slot_r    <= in_key[IDXW-1:0];
      steps_r   <= '0;
    end else if (cmd.step) begin
      slot_r  <= slot_step;
      steps_r <= SW'(steps_r + 1'b1);
    end
  end

  // Result of the finishing operation
  always_comb begin
    count_nxt = count_r;
    if (is_insert) begin
      res_hit  = 1'b1;
      res_data = '0;
      res_over = rd_valid;
      if (!rd_valid) begin
        count_nxt = SW'(count_r + 1'b1);
      end
    end else begin
      res_hit  = rd_valid && key_eq;
      res_data = res_hit ? DATA_OUT_W'(rd_data) : '0;
      res_over = 1'b0;
    end
  end

  // Control state: count, clearing index, result strobe
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      clr_idx_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= cmd.finish;
      if (cmd.finish) begin
        count_r <= count_nxt;
      end
      if (cmd.clear) begin
        clr_idx_r <= IDXW'(clr_idx_r + 1'b1);
      end
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      out_hit_r    <= res_hit;
      out_data_r   <= res_data;
      out_probes_r <= CNT_OUT_W'(steps_r);
      out_over_r   <= res_over;
      out_count_r  <= CNT_OUT_W'(count_nxt);
    end
  end

  assign out_valid        = out_valid_r;
  assign out_hit          = out_hit_r;
  assign out_data_out     = out_data_r;
  assign out_probes_taken = out_probes_r;
  assign out_overwrote    = out_over_r;
  assign out_entry_count  = out_count_r;

  // Checks
  `ASSERT_NEXT(a_single_strobe, clk, rst_n, out_valid_r, !out_valid_r)
  `ASSERT_IMPL(a_count_bound, clk, rst_n, 1'b1, count_r <= SW'(CAPACITY))
  `ASSERT_IMPL(a_over_is_insert, clk, rst_n, out_valid_r && out_over_r, out_hit_r)
  `ASSERT_IMPL(a_full_no_probe, clk, rst_n, cmd.step && is_insert, !full)

endmodule

>>> src/hash_table_probe_engine.sv
// Top level of the hash table probe engine: controller plus datapath.
//
//   channel  | handshake              | payload
//   ---------+------------------------+--------------------------------------------
//   input    | start, busy            | in_command, in_key, in_entry_data
//   result   | out_valid (strobe)     | out_hit, out_data_out, out_probes_taken,
//            |                        | out_overwrote, out_entry_count
//
// A transfer in takes place when start is high and busy is low.
// One probe per cycle through the single read port of the slot memory; busy stays high
// while the probes run, and the result strobe is registered as the last probe finishes.
// After reset a clearing pass empties the table slot by slot with busy high.
// Reset is synchronous, active low. The result stands for one cycle and cannot be stalled.
module hash_table_probe_engine #(
  parameter int unsigned CAPACITY   = htpe_pkg::CAPACITY_DEF,
  parameter int unsigned DATA_WIDTH = htpe_pkg::DATA_WIDTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  output logic                            busy,
  input  logic                            in_command,
  input  logic [htpe_pkg::KEY_W-1:0]      in_key,
  input  logic [htpe_pkg::DATA_OUT_W-1:0] in_entry_data,
  output logic                            out_valid,
  output logic                            out_hit,
  output logic [htpe_pkg::DATA_OUT_W-1:0] out_data_out,
  output logic [htpe_pkg::CNT_OUT_W-1:0]  out_probes_taken,
  output logic                            out_overwrote,
  output logic [htpe_pkg::CNT_OUT_W-1:0]  out_entry_count
);
  import htpe_pkg::*;

  htpe_cmd_t cmd;
  htpe_sts_t sts;

  // Sequencer
  htpe_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .cmd   (cmd),
    .sts   (sts)
  );

  // Slot memory and probe datapath
  htpe_datapath #(
    .CAPACITY   (CAPACITY),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_datapath (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .sts              (sts),
    .in_command       (in_command),
    .in_key           (in_key),
    .in_entry_data    (in_entry_data),
    .out_valid        (out_valid),
    .out_hit          (out_hit),
    .out_data_out     (out_data_out),
    .out_probes_taken (out_probes_taken),
    .out_overwrote    (out_overwrote),
    .out_entry_count  (out_entry_count)
  );

endmodule

>>> dv/hash_table_probe_engine_test.sv
// Self-checking testbench of the hash table probe engine: directed rows, then random ops.
module hash_table_probe_engine_test;
  import htpe_pkg::*;

  localparam int unsigned TABLE_SLOTS  = CAPACITY_DEF;
  localparam int unsigned IDX_W        = $clog2(TABLE_SLOTS);
  localparam int unsigned LIMIT_CYCLES = 5_000_000;
  localparam int unsigned TAIL_CYCLES  = 20;
  localparam int unsigned REPORT_MAX   = 10;

  // One result of the block, in port order
  typedef struct packed {
    logic                  hit;
    logic [DATA_OUT_W-1:0] data_out;
    logic [CNT_OUT_W-1:0]  probes;
    logic                  overwrote;
    logic [CNT_OUT_W-1:0]  count;
  } probe_result_t;

  // One directed row; typed_in rows carry their own expected result
  typedef struct {
    logic                  cmd;
    logic [KEY_W-1:0]      key;
    logic [DATA_OUT_W-1:0] entry_data;
    bit                    typed_in;
    probe_result_t         want;
  } op_row_t;

  typedef enum int {KEY_FRESH, KEY_STORED, KEY_SAME_HOME} key_kind_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  start = 1'b0;
  logic                  in_command = CMD_INSERT;
  logic [KEY_W-1:0]      in_key = '0;
  logic [DATA_OUT_W-1:0] in_entry_data = '0;
  logic                  busy;
  logic                  out_valid;
  logic                  out_hit;
  logic [DATA_OUT_W-1:0] out_data_out;
  logic [CNT_OUT_W-1:0]  out_probes_taken;
  logic                  out_overwrote;
  logic [CNT_OUT_W-1:0]  out_entry_count;

  // Shadow copy of the slot table
  bit                    shadow_valid [TABLE_SLOTS];
  logic [KEY_W-1:0]      shadow_key   [TABLE_SLOTS];
  logic [DATA_OUT_W-1:0] shadow_data  [TABLE_SLOTS];
  int unsigned           fill_count = 0;

  probe_result_t         pending_results [$];
  logic [KEY_W-1:0]      stored_keys [$];
  op_row_t               directed_rows [$];
  int unsigned           fail_count = 0;
  int unsigned           burst_left = 1;
  int unsigned           cycle_count = 0;
  probe_result_t         observed;
  probe_result_t         expected_head;

  hash_table_probe_engine #(
    .CAPACITY  (TABLE_SLOTS),
    .DATA_WIDTH(DATA_WIDTH_DEF)
  ) dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_command      (in_command),
    .in_key          (in_key),
    .in_entry_data   (in_entry_data),
    .out_valid       (out_valid),
    .out_hit         (out_hit),
    .out_data_out    (out_data_out),
    .out_probes_taken(out_probes_taken),
    .out_overwrote   (out_overwrote),
    .out_entry_count (out_entry_count)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  // Probe the shadow table as the block does and commit inserts
  function automatic probe_result_t probe_table(input logic cmd, input logic [KEY_W-1:0] key,
                                                input logic [DATA_OUT_W-1:0] entry_data);
    int unsigned   slot;
    int unsigned   steps;
    bit            occupied;
    bit            full;
    probe_result_t r;
    slot  = int'(key[IDX_W-1:0]);
    steps = 0;
    r     = '0;
    if (cmd == CMD_INSERT) begin
      full     = (fill_count >= TABLE_SLOTS);
      occupied = shadow_valid[slot];
      while (occupied && !full && steps < TABLE_SLOTS) begin
        slot     = (slot + steps) % TABLE_SLOTS;
        occupied = shadow_valid[slot];
        steps++;
      end
      r.overwrote        = shadow_valid[slot];
      shadow_valid[slot] = 1'b1;
      shadow_key[slot]   = key;
      shadow_data[slot]  = entry_data;
      if (!r.overwrote) fill_count++;
      r.hit = 1'b1;
    end else begin
      occupied = shadow_valid[slot];
      while (occupied && shadow_key[slot] != key && steps < TABLE_SLOTS) begin
        slot     = (slot + steps) % TABLE_SLOTS;
        occupied = shadow_valid[slot];
        steps++;
      end
      if (shadow_valid[slot] && shadow_key[slot] == key) begin
        r.hit      = 1'b1;
        r.data_out = shadow_data[slot];
      end
    end
    r.probes = steps[CNT_OUT_W-1:0];
    r.count  = fill_count[CNT_OUT_W-1:0];
    return r;
  endfunction

  function automatic logic [KEY_W-1:0] draw_key(input key_kind_t kind);
    logic [KEY_W-1:0] fresh;
    logic [KEY_W-1:0] known;
    fresh = {$urandom(), $urandom()};
    known = stored_keys[$urandom_range(0, stored_keys.size() - 1)];
    case (kind)
      KEY_STORED:    return known;
      KEY_SAME_HOME: return {fresh[KEY_W-1:IDX_W], known[IDX_W-1:0]};
      default:       return fresh;
    endcase
  endfunction

  task automatic add_row(input logic cmd, input logic [KEY_W-1:0] key,
                         input logic [DATA_OUT_W-1:0] entry_data, input bit typed_in,
                         input probe_result_t want);
    op_row_t row;
    row.cmd        = cmd;
    row.key        = key;
    row.entry_data = entry_data;
    row.typed_in   = typed_in;
    row.want       = want;
    directed_rows.push_back(row);
  endtask

  // Drive one command with start high until busy is low, then record what it must return
  task automatic apply_op(input logic cmd, input logic [KEY_W-1:0] key,
                          input logic [DATA_OUT_W-1:0] entry_data, input bit typed_in,
                          input probe_result_t want);
    probe_result_t predicted;
    start         <= 1'b1;
    in_command    <= cmd;
    in_key        <= key;
    in_entry_data <= entry_data;
    @(posedge clk);
    while (busy) @(posedge clk);
    predicted = probe_table(cmd, key, entry_data);
    pending_results.push_back(typed_in ? want : predicted);
    if (cmd == CMD_INSERT) stored_keys.push_back(key);
    // bursts of back-to-back commands with random gaps between them
    burst_left--;
    if (burst_left == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
      burst_left = $urandom_range(1, 24);
    end
  endtask

  task automatic random_op(input int unsigned insert_pct, input int unsigned hit_pct);
    logic        cmd;
    int unsigned roll;
    key_kind_t   kind;
    cmd  = ($urandom_range(0, 99) < insert_pct) ? CMD_INSERT : CMD_LOOKUP;
    roll = $urandom_range(0, 99);
    if (cmd == CMD_INSERT)
      kind = (roll < 10) ? KEY_STORED : (roll < 30) ? KEY_SAME_HOME : KEY_FRESH;
    else
      kind = (roll < hit_pct) ? KEY_STORED : (roll < hit_pct + 20) ? KEY_SAME_HOME : KEY_FRESH;
    apply_op(cmd, draw_key(kind), {$urandom(), $urandom()}, 1'b0, '0);
  endtask

  task automatic drain_results();
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // Result checker: every strobe must match the oldest expectation
  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      observed = {out_hit, out_data_out, out_probes_taken, out_overwrote, out_entry_count};
      if (pending_results.size() == 0) begin
        fail_count++;
        if (fail_count <= REPORT_MAX)
          $display("unexpected result: hit %0b data %h probes %0d overwrote %0b count %0d",
                   observed.hit, observed.data_out, observed.probes, observed.overwrote,
                   observed.count);
      end else begin
        expected_head = pending_results.pop_front();
        if (observed !== expected_head) begin
          fail_count++;
          if (fail_count <= REPORT_MAX)
            $display({"mismatch (exp/got): hit %0b/%0b data %h/%h probes %0d/%0d ",
                      "overwrote %0b/%0b count %0d/%0d"},
                     expected_head.hit, observed.hit, expected_head.data_out, observed.data_out,
                     expected_head.probes, observed.probes, expected_head.overwrote,
                     observed.overwrote, expected_head.count, observed.count);
        end
      end
    end
  end

  // Watchdog
  initial begin
    while (cycle_count < LIMIT_CYCLES) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Some tests failed");
    $finish;
  end

  initial begin
    // empty table: miss, then extremes of key and data, home collisions and wrap
    add_row(CMD_LOOKUP, 64'h0, 64'h0, 1'b1, {1'b0, 64'h0, 11'd0, 1'b0, 11'd0});
    add_row(CMD_INSERT, 64'h0, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1, {1'b1, 64'h0, 11'd0, 1'b0, 11'd1});
    add_row(CMD_LOOKUP, 64'h0, 64'h0, 1'b1,
            {1'b1, 64'hFFFF_FFFF_FFFF_FFFF, 11'd0, 1'b0, 11'd1});
    add_row(CMD_INSERT, 64'hFFFF_FFFF_FFFF_FFFF, 64'h0, 1'b1, {1'b1, 64'h0, 11'd0, 1'b0, 11'd2});
    add_row(CMD_LOOKUP, 64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1,
            {1'b1, 64'h0, 11'd0, 1'b0, 11'd2});
    add_row(CMD_INSERT, 64'h400, 64'hA5A5_A5A5_A5A5_A5A5, 1'b0, '0);
    add_row(CMD_LOOKUP, 64'h400, 64'h0, 1'b0, '0);
    add_row(CMD_LOOKUP, 64'h800, 64'h0, 1'b0, '0);
    // home at the last slot, probe wraps to the bottom of the table
    add_row(CMD_INSERT, 64'hFFFF_FFFF_FFFF_FBFF, 64'h5A5A_5A5A_5A5A_5A5A, 1'b0, '0);
    add_row(CMD_LOOKUP, 64'hFFFF_FFFF_FFFF_FBFF, 64'h0, 1'b0, '0);
    // duplicate key: the older entry stays the one found
    add_row(CMD_INSERT, 64'h0, 64'h0123_4567_89AB_CDEF, 1'b0, '0);
    add_row(CMD_LOOKUP, 64'h0, 64'h0, 1'b0, '0);
    add_row(CMD_LOOKUP, 64'h1, 64'hDEAD_BEEF_0000_0001, 1'b0, '0);
    add_row(CMD_INSERT, 64'h8000_0000_0000_0005, 64'h8000_0000_0000_0001, 1'b0, '0);
    add_row(CMD_LOOKUP, 64'h5, 64'h0, 1'b0, '0);
    add_row(CMD_LOOKUP, 64'h8000_0000_0000_0005, 64'h0, 1'b0, '0);

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed_rows[i])
      apply_op(directed_rows[i].cmd, directed_rows[i].key, directed_rows[i].entry_data,
               directed_rows[i].typed_in, directed_rows[i].want);
    drain_results();

    // moderate load: inserts and lookups evenly mixed
    repeat (120) random_op(50, 50);
    drain_results();

    // fill the table to capacity; probe chains grow long near the end
    while (fill_count < TABLE_SLOTS) random_op(96, 60);
    drain_results();

    // full table: inserts overwrite home, misses run the whole probe sequence
    repeat (60) random_op(40, 50);
    drain_results();

    repeat (TAIL_CYCLES) @(posedge clk);
    if (fail_count == 0 && pending_results.size() == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

endmodule
